>>> src/polyphase_audio_resampler_core_assert.svh
// Assertion macros shared by the resampler checker.
`ifndef POLYPHASE_AUDIO_RESAMPLER_CORE_ASSERT_SVH
`define POLYPHASE_AUDIO_RESAMPLER_CORE_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define PRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("resampler check failed");

// Payload must hold while its transaction is stalled.
`define PRS_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error("payload changed while stalled");

`endif

>>> src/prs_pkg.sv
// Shared constants, kernel table and types of the polyphase resampler.
`default_nettype none

package prs_pkg;

  localparam int TAPS        = 8;
  localparam int PHASES      = 32;
  localparam int SAMPLE_BITS = 20;

  localparam int TAP_BITS   = $clog2(TAPS);
  localparam int ROW_BITS   = $clog2(PHASES);
  localparam int COEF_BITS  = 16;
  localparam int FRAC_BITS  = 14;
  localparam int OUT_BITS   = 16;
  localparam int OUT_MAX    = 32767;
  localparam int OUT_MIN    = -32768;

  localparam int PHASE_BITS = 32;
  localparam int STEP_BITS  = 37;
  localparam int CARRY_BITS = STEP_BITS - PHASE_BITS + 1;
  localparam int CNT_BITS   = 5;
  localparam int CNT_MAX    = 31;
  localparam logic [CNT_BITS-1:0] CNT_RESET = CNT_BITS'(TAPS);

  localparam logic [STEP_BITS-1:0] STEP_MIN   = 37'h0004000000;
  localparam logic [STEP_BITS-1:0] STEP_MAX   = 37'h1000000000;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 37'h0100000000;

  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_MODE = 2'd1;

  // Channel modes; the unused code behaves as mono
  localparam int MODE_BITS = 2;
  localparam logic [MODE_BITS-1:0] MODE_MONO   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_DUP    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_STEREO = 2'd2;

  typedef struct packed {
    logic [STEP_BITS-1:0] phase_step;
    logic [MODE_BITS-1:0] channel_mode;
  } prs_cfg_t;

  // Q14 windowed-sinc kernel, one row per phase, oldest tap first
  localparam logic signed [COEF_BITS-1:0] KERN [PHASES][TAPS] = '{
    '{ 16'sh0000,  16'sh0000,  16'sh0000,  16'sh4000,
       16'sh0000,  16'sh0000,  16'sh0000,  16'sh0000},
    '{-16'sh000a,  16'sh0052, -16'sh0179,  16'sh3fe2,
       16'sh019f, -16'sh005b,  16'sh000c,  16'sh0000},
    '{-16'sh0013,  16'sh009c, -16'sh02cc,  16'sh3f86,
       16'sh0362, -16'sh00c0,  16'sh001a,  16'sh0000},
    '{-16'sh001a,  16'sh00dc, -16'sh03f9,  16'sh3eef,
       16'sh054a, -16'sh012c,  16'sh002b,  16'sh0000},
    '{-16'sh001f,  16'sh0113, -16'sh0500,  16'sh3e1d,
       16'sh0753, -16'sh01a0,  16'sh003d,  16'sh0000},
    '{-16'sh0023,  16'sh0141, -16'sh05e1,  16'sh3d12,
       16'sh097c, -16'sh021a,  16'sh0050, -16'sh0001},
    '{-16'sh0026,  16'sh0166, -16'sh069e,  16'sh3bd0,
       16'sh0bc4, -16'sh029a,  16'sh0066, -16'sh0001},
    '{-16'sh0027,  16'sh0182, -16'sh0738,  16'sh3a5a,
       16'sh0e27, -16'sh031f,  16'sh007d, -16'sh0002},
    '{-16'sh0028,  16'sh0197, -16'sh07b0,  16'sh38b2,
       16'sh10a2, -16'sh03a7,  16'sh0096, -16'sh0003},
    '{-16'sh0027,  16'sh01a5, -16'sh0807,  16'sh36dc,
       16'sh1333, -16'sh0430,  16'sh00af, -16'sh0005},
    '{-16'sh0026,  16'sh01ab, -16'sh083f,  16'sh34db,
       16'sh15d5, -16'sh04ba,  16'sh00ca, -16'sh0007},
    '{-16'sh0024,  16'sh01ac, -16'sh085b,  16'sh32b3,
       16'sh1886, -16'sh0541,  16'sh00e5, -16'sh0008},
    '{-16'sh0022,  16'sh01a6, -16'sh085d,  16'sh3068,
       16'sh1b40, -16'sh05c6,  16'sh0101, -16'sh000b},
    '{-16'sh001f,  16'sh019c, -16'sh0846,  16'sh2dfe,
       16'sh1e00, -16'sh0644,  16'sh011c, -16'sh000d},
    '{-16'sh001c,  16'sh018e, -16'sh0819,  16'sh2b7a,
       16'sh20c1, -16'sh06bb,  16'sh0136, -16'sh0010},
    '{-16'sh0019,  16'sh017c, -16'sh07d9,  16'sh28e1,
       16'sh2380, -16'sh0727,  16'sh014f, -16'sh0013},
    '{-16'sh0016,  16'sh0167, -16'sh0788,  16'sh2637,
       16'sh2637, -16'sh0788,  16'sh0167, -16'sh0016},
    '{-16'sh0013,  16'sh014f, -16'sh0727,  16'sh2380,
       16'sh28e1, -16'sh07d9,  16'sh017c, -16'sh0019},
    '{-16'sh0010,  16'sh0136, -16'sh06bb,  16'sh20c1,
       16'sh2b7a, -16'sh0819,  16'sh018e, -16'sh001c},
    '{-16'sh000d,  16'sh011c, -16'sh0644,  16'sh1e00,
       16'sh2dfe, -16'sh0846,  16'sh019c, -16'sh001f},
    '{-16'sh000b,  16'sh0101, -16'sh05c6,  16'sh1b40,
       16'sh3068, -16'sh085d,  16'sh01a6, -16'sh0022},
    '{-16'sh0008,  16'sh00e5, -16'sh0541,  16'sh1886,
       16'sh32b3, -16'sh085b,  16'sh01ac, -16'sh0024},
    '{-16'sh0007,  16'sh00ca, -16'sh04ba,  16'sh15d5,
       16'sh34db, -16'sh083f,  16'sh01ab, -16'sh0026},
    '{-16'sh0005,  16'sh00af, -16'sh0430,  16'sh1333,
       16'sh36dc, -16'sh0807,  16'sh01a5, -16'sh0027},
    '{-16'sh0003,  16'sh0096, -16'sh03a7,  16'sh10a2,
       16'sh38b2, -16'sh07b0,  16'sh0197, -16'sh0028},
    '{-16'sh0002,  16'sh007d, -16'sh031f,  16'sh0e27,
       16'sh3a5a, -16'sh0738,  16'sh0182, -16'sh0027},
    '{-16'sh0001,  16'sh0066, -16'sh029a,  16'sh0bc4,
       16'sh3bd0, -16'sh069e,  16'sh0166, -16'sh0026},
    '{-16'sh0001,  16'sh0050, -16'sh021a,  16'sh097c,
       16'sh3d12, -16'sh05e1,  16'sh0141, -16'sh0023},
    '{ 16'sh0000,  16'sh003d, -16'sh01a0,  16'sh0753,
       16'sh3e1d, -16'sh0500,  16'sh0113, -16'sh001f},
    '{ 16'sh0000,  16'sh002b, -16'sh012c,  16'sh054a,
       16'sh3eef, -16'sh03f9,  16'sh00dc, -16'sh001a},
    '{ 16'sh0000,  16'sh001a, -16'sh00c0,  16'sh0362,
       16'sh3f86, -16'sh02cc,  16'sh009c, -16'sh0013},
    '{ 16'sh0000,  16'sh000c, -16'sh005b,  16'sh019f,
       16'sh3fe2, -16'sh0179,  16'sh0052, -16'sh000a}
  };

  function automatic logic signed [COEF_BITS-1:0] kern_coef(
    input logic [ROW_BITS-1:0] row,
    input logic [TAP_BITS-1:0] tap
  );
    return KERN[row][tap];
  endfunction

endpackage

`default_nettype wire

>>> src/polyphase_audio_resampler_core.sv
// Polyphase resampler: 8-tap, 32-phase Q14 FIR with a 0.32 phase accumulator.
// Each input transaction lands in a two-entry queue. The back end shifts it into
// the left and right windows at the edge where it leaves the queue, at the
// earliest in the cycle after it is accepted. Once the needed samples are in, the
// block emits results until the phase carry asks for more input. For each result
// the shared pair of 20x16 multipliers steps one tap per cycle through the windows,
// the product register drains, and the final state rounds, clamps and steps the
// phase, waiting there while the output stalls. The back end pops no new input
// until the run ends. Configuration (phase_step clamped to 1/64..16, channel_mode)
// is to be written by the user only while idle; the block does not enforce this.
`default_nettype none

module polyphase_audio_resampler_core
  import prs_pkg::*;
#(
  parameter int SAMPLE_BITS = prs_pkg::SAMPLE_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic     [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic     [STEP_BITS-1:0]    cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed   [OUT_BITS-1:0]     left_out_o,
  output logic signed   [OUT_BITS-1:0]     right_out_o,
  output logic                             last_of_run_o
);

  prs_cfg_t                   cfg_q, cfg_d;
  logic                       q_valid, q_pop;
  logic [2*SAMPLE_BITS-1:0]   q_data;

  // Decode configuration writes, clamp the step into range
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PHASE_STEP: begin
          if (cfg_wdata_i < STEP_MIN) begin
            cfg_d.phase_step = STEP_MIN;
          end else if (cfg_wdata_i > STEP_MAX) begin
            cfg_d.phase_step = STEP_MAX;
          end else begin
            cfg_d.phase_step = cfg_wdata_i;
          end
        end
        REG_CHANNEL_MODE: cfg_d.channel_mode = cfg_wdata_i[MODE_BITS-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step   <= STEP_RESET;
      cfg_q.channel_mode <= MODE_MONO;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  prs_queue #(
    .WIDTH (2 * SAMPLE_BITS)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  ({right_sample_i, left_sample_i}),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_data)
  );

  prs_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

>>> src/prs_queue.sv
// Front end: two-entry queue that takes input transactions ahead of the filter engine.
`default_nettype none

module prs_queue
  import prs_pkg::*;
#(
  parameter int WIDTH = 2 * SAMPLE_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o
);

  localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]      mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  push, pop;

  assign push_ready_o = (count_q != COUNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_BITS'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_BITS'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + COUNT_BITS'(1);
    end else if (pop && !push) begin
      count_d = count_q - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/prs_back.sv
// Back end: sample windows, phase tracking and the serial multiply-accumulate engine.
`default_nettype none

module prs_back
  import prs_pkg::*;
#(
  parameter int SAMPLE_BITS = prs_pkg::SAMPLE_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire prs_cfg_t                     cfg_i,
  input  wire logic                         q_valid_i,
  input  wire logic     [2*SAMPLE_BITS-1:0] q_data_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed   [OUT_BITS-1:0]      left_out_o,
  output logic signed   [OUT_BITS-1:0]      right_out_o,
  output logic                              last_of_run_o
);

  localparam int PW = SAMPLE_BITS + COEF_BITS;
  localparam int AW = PW + TAP_BITS;
  localparam logic [TAP_BITS-1:0] TAP_LAST = TAP_BITS'(TAPS - 1);
  localparam logic signed [AW:0] RND_BIAS = (AW+1)'(1 << (FRAC_BITS - 1));
  localparam logic signed [AW:0] SAT_HI   = (AW+1)'(OUT_MAX);
  localparam logic signed [AW:0] SAT_LO   = (AW+1)'(OUT_MIN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ROUND
  } state_e;

  state_e                        state_q, state_d;
  logic signed [SAMPLE_BITS-1:0] win_l_q [TAPS];
  logic signed [SAMPLE_BITS-1:0] win_l_d [TAPS];
  logic signed [SAMPLE_BITS-1:0] win_r_q [TAPS];
  logic signed [SAMPLE_BITS-1:0] win_r_d [TAPS];
  logic [CNT_BITS-1:0]           cnt_q, cnt_d, cnt_dec;
  logic [PHASE_BITS-1:0]         phase_q, phase_d;
  logic [TAP_BITS-1:0]           tap_q, tap_d;
  logic                          pv_q, pv_d;
  logic signed [PW-1:0]          prod_l_q, prod_l_d, prod_r_q, prod_r_d;
  logic signed [AW-1:0]          acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [OUT_BITS-1:0]    left_q, left_d, right_q, right_d;
  logic                          last_q, last_d;

  logic signed [COEF_BITS-1:0]   coef;
  logic [PHASE_BITS+CARRY_BITS-1:0] phase_sum;
  logic [CARRY_BITS-1:0]         carry;
  logic signed [OUT_BITS-1:0]    rnd_l, rnd_r;

  // Round half up, drop the Q14 fraction, clamp to the output range
  function automatic logic signed [OUT_BITS-1:0] round_sat(input logic signed [AW-1:0] s);
    logic signed [AW:0] b;
    logic signed [AW:0] sh;
    b  = (AW+1)'(s) + RND_BIAS;
    sh = b >>> FRAC_BITS;
    if (sh > SAT_HI) begin
      return OUT_BITS'(OUT_MAX);
    end else if (sh < SAT_LO) begin
      return OUT_BITS'(OUT_MIN);
    end
    return sh[OUT_BITS-1:0];
  endfunction

  assign coef      = kern_coef(phase_q[PHASE_BITS-1 -: ROW_BITS], tap_q);
  assign phase_sum = (PHASE_BITS+CARRY_BITS)'(phase_q)
                   + (PHASE_BITS+CARRY_BITS)'(cfg_i.phase_step);
  assign carry     = phase_sum[PHASE_BITS+CARRY_BITS-1:PHASE_BITS];
  assign cnt_dec   = (cnt_q != '0) ? cnt_q - CNT_BITS'(1) : cnt_q;
  assign rnd_l     = round_sat(acc_l_q);
  assign rnd_r     = round_sat(acc_r_q);

  always_comb begin
    state_d     = state_q;
    win_l_d     = win_l_q;
    win_r_d     = win_r_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    tap_d       = tap_q;
    pv_d        = pv_q;
    prod_l_d    = prod_l_q;
    prod_r_d    = prod_r_q;
    acc_l_d     = acc_l_q;
    acc_r_d     = acc_r_q;
    left_d      = left_q;
    right_d     = right_q;
    last_d      = last_q;
    q_pop_o     = 1'b0;
    // Drop the result once its transaction completes
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          // Shift the new sample pair into both windows
          q_pop_o = 1'b1;
          for (int i = 0; i < TAPS - 1; i++) begin
            win_l_d[i] = win_l_q[i+1];
            win_r_d[i] = win_r_q[i+1];
          end
          win_l_d[TAPS-1] = q_data_i[SAMPLE_BITS-1:0];
          win_r_d[TAPS-1] = q_data_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            state_d = S_MAC;
            tap_d   = '0;
            pv_d    = 1'b0;
            acc_l_d = '0;
            acc_r_d = '0;
          end
        end
      end
      S_MAC: begin
        // One tap per cycle, product registered before accumulation
        prod_l_d = PW'(win_l_q[tap_q]) * PW'(coef);
        prod_r_d = PW'(win_r_q[tap_q]) * PW'(coef);
        pv_d     = 1'b1;
        if (pv_q) begin
          acc_l_d = acc_l_q + AW'(prod_l_q);
          acc_r_d = acc_r_q + AW'(prod_r_q);
        end
        tap_d = tap_q + TAP_BITS'(1);
        if (tap_q == TAP_LAST) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        acc_l_d = acc_l_q + AW'(prod_l_q);
        acc_r_d = acc_r_q + AW'(prod_r_q);
        pv_d    = 1'b0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          left_d      = rnd_l;
          last_d      = (carry != '0);
          unique case (cfg_i.channel_mode)
            MODE_DUP:    right_d = rnd_l;
            MODE_STEREO: right_d = rnd_r;
            default:     right_d = '0;
          endcase
          // Step the phase; a carry ends the run
          phase_d = phase_sum[PHASE_BITS-1:0];
          if (carry != '0) begin
            cnt_d   = (carry > CARRY_BITS'(CNT_MAX)) ? CNT_BITS'(CNT_MAX)
                                                     : carry[CNT_BITS-1:0];
            state_d = S_IDLE;
          end else begin
            state_d = S_MAC;
            tap_d   = '0;
            acc_l_d = '0;
            acc_r_d = '0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < TAPS; i++) begin
        win_l_q[i] <= '0;
        win_r_q[i] <= '0;
      end
      cnt_q       <= CNT_RESET;
      phase_q     <= '0;
      tap_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_l_q     <= win_l_d;
      win_r_q     <= win_r_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      tap_q       <= tap_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers; no reset needed
  always_ff @(posedge clk_i) begin
    prod_l_q <= prod_l_d;
    prod_r_q <= prod_r_d;
    acc_l_q  <= acc_l_d;
    acc_r_q  <= acc_r_d;
    left_q   <= left_d;
    right_q  <= right_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign left_out_o    = left_q;
  assign right_out_o   = right_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

>>> src/prs_checker.sv
// Port-level checker for the resampler, bound to the top level.
`default_nettype none

`include "polyphase_audio_resampler_core_assert.svh"

module prs_checker
  import prs_pkg::*;
#(
  parameter int SAMPLE_BITS = prs_pkg::SAMPLE_BITS
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        cfg_we_i,
  input wire logic     [CFG_IDX_BITS-1:0] cfg_idx_i,
  input wire logic     [STEP_BITS-1:0]    cfg_wdata_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic signed [OUT_BITS-1:0]  left_out_o,
  input wire logic signed [OUT_BITS-1:0]  right_out_o
);

  logic [MODE_BITS-1:0] mode_q;
  logic                 mono, dup;

  // Track the channel mode as written on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MONO;
    end else if (cfg_we_i && (cfg_idx_i == REG_CHANNEL_MODE)) begin
      mode_q <= cfg_wdata_i[MODE_BITS-1:0];
    end
  end

  assign mono = (mode_q != MODE_DUP) && (mode_q != MODE_STEREO);
  assign dup  = (mode_q == MODE_DUP);

  `PRS_ASSERT(a_out_valid_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `PRS_ASSERT_HOLD(a_left_out_stable, out_valid_o, out_ready_i, left_out_o)
  `PRS_ASSERT(a_mono_right_zero, out_valid_o && mono |-> right_out_o == '0)
  `PRS_ASSERT(a_dup_right_copy, out_valid_o && dup |-> right_out_o == left_out_o)

endmodule

bind polyphase_audio_resampler_core prs_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_prs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .left_out_o    (left_out_o),
  .right_out_o   (right_out_o)
);

`default_nettype wire

>>> tb/sv/polyphase_audio_resampler_core_test.sv
// Self-checking testbench for the polyphase audio resampler core.
`default_nettype none

module polyphase_audio_resampler_core_test;
  import prs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_RUN       = 64;

  // Codes the package leaves unnamed
  localparam logic [MODE_BITS-1:0]    MODE_SPARE  = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] left;
    logic signed [OUT_BITS-1:0] right;
    logic                       last;
  } out_frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [STEP_BITS-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SAMPLE_BITS-1:0] left_sample_i = '0;
  logic signed [SAMPLE_BITS-1:0] right_sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OUT_BITS-1:0] left_out_o;
  logic signed [OUT_BITS-1:0] right_out_o;
  logic last_of_run_o;

  polyphase_audio_resampler_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Resampler state as the block should hold it
  logic signed [SAMPLE_BITS-1:0] left_hist  [TAPS] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] right_hist [TAPS] = '{default: '0};
  logic [PHASE_BITS-1:0] phase_acc = '0;
  logic [CNT_BITS-1:0]   need_count = CNT_RESET;
  logic [STEP_BITS-1:0]  step_reg = STEP_RESET;
  logic [MODE_BITS-1:0]  mode_reg = MODE_MONO;

  out_frame_t expected_frames [$];
  int mismatch_count = 0;
  int unsigned cycle_count = 0;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int walk_level = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Apply one register write to the expected configuration
  function automatic void load_register(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [STEP_BITS-1:0] data);
    case (idx)
      REG_PHASE_STEP: begin
        if (data < STEP_MIN) step_reg = STEP_MIN;
        else if (data > STEP_MAX) step_reg = STEP_MAX;
        else step_reg = data;
      end
      REG_CHANNEL_MODE: mode_reg = data[MODE_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Filter one channel history with one kernel row, round and clamp to int16
  function automatic logic signed [OUT_BITS-1:0] fir_output(input bit use_right,
                                                            input logic [ROW_BITS-1:0] row);
    longint acc;
    longint q;
    int t;
    acc = 0;
    for (t = 0; t < TAPS; t++)
      acc += longint'(use_right ? right_hist[t] : left_hist[t]) * longint'(KERN[row][t]);
    q = (acc + 8192) >>> FRAC_BITS;
    if (q > OUT_MAX) q = OUT_MAX;
    if (q < OUT_MIN) q = OUT_MIN;
    return q[OUT_BITS-1:0];
  endfunction

  // Shift one sample pair in and queue every output frame it releases
  function automatic void predict_resampled(input logic signed [SAMPLE_BITS-1:0] l,
                                            input logic signed [SAMPLE_BITS-1:0] r);
    out_frame_t f;
    logic [ROW_BITS-1:0] row;
    logic [63:0] nxt;
    logic [31:0] carry;
    int t;
    for (t = 0; t < TAPS - 1; t++) begin
      left_hist[t]  = left_hist[t+1];
      right_hist[t] = right_hist[t+1];
    end
    left_hist[TAPS-1]  = l;
    right_hist[TAPS-1] = r;
    if (need_count != 0) need_count = need_count - 1'b1;
    if (need_count != 0) return;
    for (t = 0; t < MAX_RUN; t++) begin
      row = phase_acc[PHASE_BITS-1 -: ROW_BITS];
      f.left = fir_output(1'b0, row);
      if (mode_reg == MODE_DUP) f.right = f.left;
      else if (mode_reg == MODE_STEREO) f.right = fir_output(1'b1, row);
      else f.right = '0;
      nxt = 64'(phase_acc) + 64'(step_reg);
      phase_acc = nxt[31:0];
      carry = nxt[63:32];
      f.last = (carry != 0) || (t == MAX_RUN - 1);
      expected_frames.push_back(f);
      if (carry != 0) begin
        need_count = (carry > CNT_MAX) ? CNT_BITS'(CNT_MAX) : carry[CNT_BITS-1:0];
        break;
      end
    end
  endfunction

  function automatic void report_field(input string name, input int want, input int got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endfunction

  // Check output transactions, then track input transactions and writes
  always @(posedge clk_i) begin
    out_frame_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual left %0d right %0d",
                   $time, left_out_o, right_out_o);
        end else begin
          want = expected_frames.pop_front();
          if (left_out_o !== want.left) report_field("left_out", want.left, left_out_o);
          if (right_out_o !== want.right) report_field("right_out", want.right, right_out_o);
          if (last_of_run_o !== want.last)
            report_field("last_of_run", int'(want.last), int'(last_of_run_o));
        end
      end
      if (in_valid_i && in_ready_o) predict_resampled(left_sample_i, right_sample_i);
      if (cfg_we_i) load_register(cfg_idx_i, cfg_wdata_i);
    end
  end

  // Drive output ready: random stalls, or a long hold when one is requested
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Bound the run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      case ($urandom_range(0, 3))
        0: v = 524287;
        1: v = -524288;
        2: v = 0;
        default: v = -1;
      endcase
    end else if (sel < 40) begin
      v = $signed($urandom) >>> 12;
    end else if (sel < 70) begin
      v = int'($urandom_range(0, 80000)) - 40000;
    end else begin
      // Smooth walk, closer to real audio
      walk_level += int'($urandom_range(0, 8192)) - 4096;
      if (walk_level > 60000) walk_level = 60000;
      if (walk_level < -60000) walk_level = -60000;
      v = walk_level;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [STEP_BITS-1:0] pick_step();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return STEP_MIN + STEP_BITS'($urandom_range(0, 255));
    if (sel < 16) return STEP_MAX - STEP_BITS'($urandom_range(0, 1 << 20));
    if (sel < 26) return {5'($urandom_range(0, 31)), 32'($urandom)};
    return {3'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
  endfunction

  // Offer one sample pair and hold it until the transaction completes
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] l,
                             input logic signed [SAMPLE_BITS-1:0] r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_sample_i <= l;
    right_sample_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [STEP_BITS-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering, wait for every pending result, then let the back end settle
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Reset configuration: unit step, mono, full-scale and clamping values
  task automatic test_reset_config();
    logic signed [SAMPLE_BITS-1:0] vals [10];
    int i;
    vals = '{20'sd524287, -20'sd524288, 20'sd0, -20'sd1, 20'sd32767,
             -20'sd32768, 20'sd32768, -20'sd32769, 20'sd1, 20'sd123456};
    for (i = 0; i < 10; i++) send_sample(vals[i], vals[9 - i]);
    wait_for_idle();
  endtask

  // Step clamping, the dup, spare and stereo channel modes and the unused register indexes
  task automatic test_modes_and_step_limits();
    cfg_write(REG_CHANNEL_MODE, STEP_BITS'(MODE_DUP));
    cfg_write(REG_PHASE_STEP, '0);
    send_sample(20'sd300000, -20'sd524288);
    send_sample(-20'sd200000, 20'sd524287);
    wait_for_idle();
    cfg_write(REG_CHANNEL_MODE, STEP_BITS'(MODE_SPARE));
    cfg_write(REG_PHASE_STEP, 37'h0080000000);
    send_sample(20'sd15000, 20'sd77777);
    send_sample(-20'sd15000, -20'sd77777);
    wait_for_idle();
    cfg_write(REG_SPARE_A, {5'($urandom), 32'($urandom)});
    cfg_write(REG_SPARE_B, {5'($urandom), 32'($urandom)});
    cfg_write(REG_CHANNEL_MODE, STEP_BITS'(MODE_STEREO));
    cfg_write(REG_PHASE_STEP, 37'h01c0000000);
    send_sample(20'sd524287, -20'sd524288);
    send_sample(-20'sd524288, 20'sd524287);
    send_sample(20'sd40000, -20'sd1);
    send_sample(-20'sd1, 20'sd40000);
    wait_for_idle();
    cfg_write(REG_PHASE_STEP, '1);
    send_sample(20'sd1000, -20'sd1000);
    send_sample(-20'sd2000, 20'sd2000);
    send_sample(20'sd3000, -20'sd3000);
    wait_for_idle();
  endtask

  // Random traffic in segments, each under a freshly drawn configuration
  task automatic test_traffic(input int src_pct, input int sink_pct, input int n_items);
    int sent;
    int seg;
    int i;
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_for_idle();
      if ($urandom_range(0, 1) != 0) begin
        cfg_write(REG_CHANNEL_MODE, STEP_BITS'($urandom_range(0, 3)));
        cfg_write(REG_PHASE_STEP, pick_step());
      end else begin
        cfg_write(REG_PHASE_STEP, pick_step());
        cfg_write(REG_CHANNEL_MODE, STEP_BITS'($urandom_range(0, 3)));
      end
      seg = $urandom_range(12, 30);
      if (seg > n_items - sent) seg = n_items - sent;
      for (i = 0; i < seg; i++) send_sample(pick_sample(), pick_sample());
      sent += seg;
    end
    wait_for_idle();
  endtask

  // Hold the output off long enough to back up the input, then drain fully
  task automatic test_output_backpressure();
    int i;
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    cfg_write(REG_CHANNEL_MODE, STEP_BITS'(MODE_STEREO));
    cfg_write(REG_PHASE_STEP, 37'h0080000000);
    hold_seq <= hold_seq + 1;
    for (i = 0; i < 30; i++) send_sample(pick_sample(), pick_sample());
    wait_for_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_modes_and_step_limits();
    test_traffic(19, 74, 110);
    test_traffic(74, 19, 110);
    test_traffic(0, 0, 110);
    test_output_backpressure();

    wait_for_idle();
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+src
src/prs_pkg.sv
src/prs_queue.sv
src/prs_back.sv
src/polyphase_audio_resampler_core.sv
src/prs_checker.sv
tb/sv/polyphase_audio_resampler_core_test.sv
